// ===== rtl/core/lts_pkg.sv =====
// ----------------------------------------------------------------------------
// LED twinkle and streak animator: shared types and functions
// Color and queue entry types, register indexes, random walk step codes and
// the per-channel arithmetic of the animator.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BASE_MIN   = 3'd0,
		CFG_BASE_MAX   = 3'd1,
		CFG_FLASH_PEAK = 3'd2,
		CFG_DECAY_STEP = 3'd3,
		CFG_OUT_MIN    = 3'd4,
		CFG_OUT_MAX    = 3'd5
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STEP_DOWN = 2'd0,
		STEP_HOLD = 2'd1,
		STEP_UP   = 2'd2
	} step_t;

	localparam logic [7:0] RST_BASE_MIN   = 8'd1;
	localparam logic [7:0] RST_BASE_MAX   = 8'd16;
	localparam logic [7:0] RST_FLASH_PEAK = 8'd255;
	localparam logic [7:0] RST_DECAY_STEP = 8'd30;
	localparam logic [7:0] RST_OUT_MIN    = 8'd1;
	localparam logic [7:0] RST_OUT_MAX    = 8'd255;
	localparam logic [7:0] RST_BASE_LEVEL = 8'd8;
	localparam logic [2:0] MOD7_LAST      = 3'd6;

	typedef struct packed {
		logic [7:0] g;
		logic [7:0] r;
		logic [7:0] b;
	} color_t;

	typedef struct packed {
		color_t base;
		color_t sa;
		color_t sb;
	} led_entry_t;

	typedef struct packed {
		logic [7:0] index;
		color_t     color;
		logic       last;
	} pixel_t;

	function automatic logic [7:0] walk_ch(logic [7:0] v, logic [1:0] code,
		logic [7:0] lo, logic [7:0] hi);
		logic signed [9:0] n;
		n = $signed({2'b00, v});
		if (code == STEP_DOWN) begin
			n = n - 10'sd1;
		end else if (code == STEP_UP) begin
			n = n + 10'sd1;
		end
		if (n < $signed({2'b00, lo})) begin
			n = $signed({2'b00, lo});
		end
		if (n > $signed({2'b00, hi})) begin
			n = $signed({2'b00, hi});
		end
		return n[7:0];
	endfunction

	function automatic logic [7:0] decay_ch(logic [7:0] v, logic [7:0] d);
		return (v > d) ? (v - d) : 8'd0;
	endfunction

	function automatic logic [7:0] merge_ch(logic [7:0] a, logic [7:0] b,
		logic [7:0] c, logic [7:0] lo, logic [7:0] hi);
		logic [9:0] s;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c};
		if (s < {2'b00, lo}) begin
			s = {2'b00, lo};
		end
		if (s > {2'b00, hi}) begin
			s = {2'b00, hi};
		end
		return s[7:0];
	endfunction

endpackage

// ===== rtl/core/lts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lts_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/led_twinkle_streak_animator_unit.sv =====
// ----------------------------------------------------------------------------
// LED twinkle and streak animator
// Computes one merged RGB pixel per LED from a random-walk base color and
// two decaying streak layers that move along the strip from frame to frame.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat carries the random draws for the next LED, in index order;
// the block counts LEDs itself and wraps after LED_COUNT beats. Each input
// beat yields exactly one output beat with the LED index, the merged color
// and a flag on the last LED of the frame. Register writes on the cfg
// channel are taken at any time and must only be issued while the block
// is idle.
// An accepted beat passes the stage-1 registers, then the output queue.
// While the receiver keeps up, the block sustains one beat per cycle: the
// per-LED memory is read at acceptance and written back in the next cycle,
// and the history rings forward a write that meets a read of the same slot.
// A two-entry output queue decouples the channels; when the receiver stalls,
// the queue fills and in_ready drops until an entry is taken.
// After reset the first frame uses the reset colors in place of memory
// contents, so no clearing pass is needed and the first beat is taken at once.
// ----------------------------------------------------------------------------
module led_twinkle_streak_animator_unit #(
	parameter int LED_COUNT       = 256,
	parameter int STREAK_A_OFFSET = 20,
	parameter int STREAK_B_OFFSET = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    step_green,
	input  logic [1:0]                    step_red,
	input  logic [1:0]                    step_blue,
	input  logic                          fire_streak_a,
	input  logic                          fire_streak_b,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    pixel_index,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_blue,
	output logic                          frame_last,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	import lts_pkg::*;

	localparam int IDX_W = $clog2(LED_COUNT);
	localparam int SA_W  = (STREAK_A_OFFSET > 1) ? $clog2(STREAK_A_OFFSET) : 1;
	localparam int SB_W  = (STREAK_B_OFFSET > 1) ? $clog2(STREAK_B_OFFSET) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
	localparam logic [SA_W-1:0]  SA_LAST  = SA_W'(STREAK_A_OFFSET - 1);
	localparam logic [SB_W-1:0]  SB_LAST  = SB_W'(STREAK_B_OFFSET - 1);

	logic [7:0] base_min_q, base_max_q, flash_peak_q, decay_step_q, out_min_q, out_max_q;

	logic [IDX_W-1:0] pos_q;
	logic [SA_W-1:0]  slot_a_q;
	logic [SB_W-1:0]  slot_b_q;
	logic [2:0]       mod7_q;
	logic             first_q;

	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [SA_W-1:0]  slot_a_s1;
	logic [SB_W-1:0]  slot_b_s1;
	logic [1:0]       step_g_s1, step_r_s1, step_b_s1;
	logic             fire_a_s1, fire_b_s1, dark_a_s1, dark_b_s1;
	logic             first_s1;
	logic [2:0]       mod7_s1;
	logic             fwd_a_s1, fwd_b_s1;
	color_t           fwd_a_data_s1, fwd_b_data_s1;

	logic       accept, pop;
	logic [2:0] occ;

	led_entry_t main_rd, main_wr;
	color_t     hist_a_rd, hist_b_rd;
	color_t     rst_base, base_cur, base_new;
	color_t     old_a, old_b, prev_a, prev_b, new_a, new_b;
	logic [2:0] rst_code;
	logic [IDX_W+7:0] idx_ext;
	pixel_t     push_item;

	pixel_t     fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_min_q   <= RST_BASE_MIN;
			base_max_q   <= RST_BASE_MAX;
			flash_peak_q <= RST_FLASH_PEAK;
			decay_step_q <= RST_DECAY_STEP;
			out_min_q    <= RST_OUT_MIN;
			out_max_q    <= RST_OUT_MAX;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BASE_MIN:   base_min_q   <= cfg_data;
				CFG_BASE_MAX:   base_max_q   <= cfg_data;
				CFG_FLASH_PEAK: flash_peak_q <= cfg_data;
				CFG_DECAY_STEP: decay_step_q <= cfg_data;
				CFG_OUT_MIN:    out_min_q    <= cfg_data;
				CFG_OUT_MAX:    out_max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pop      = out_valid && out_ready;
	assign occ      = 3'(cnt_q) + 3'(valid_s1) - 3'(pop);
	assign in_ready = occ < 3'd2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			slot_a_q <= '0;
			slot_b_q <= '0;
			mod7_q   <= '0;
			first_q  <= 1'b1;
		end else if (accept) begin
			if (pos_q == LAST_IDX) begin
				pos_q    <= '0;
				slot_a_q <= '0;
				slot_b_q <= '0;
				mod7_q   <= '0;
				first_q  <= 1'b0;
			end else begin
				pos_q    <= pos_q + 1'b1;
				slot_a_q <= (slot_a_q == SA_LAST) ? '0 : slot_a_q + 1'b1;
				slot_b_q <= (slot_b_q == SB_LAST) ? '0 : slot_b_q + 1'b1;
				mod7_q   <= (mod7_q == MOD7_LAST) ? '0 : mod7_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1        <= pos_q;
			slot_a_s1     <= slot_a_q;
			slot_b_s1     <= slot_b_q;
			step_g_s1     <= step_green;
			step_r_s1     <= step_red;
			step_b_s1     <= step_blue;
			fire_a_s1     <= fire_streak_a;
			fire_b_s1     <= fire_streak_b;
			dark_a_s1     <= int'(pos_q) < STREAK_A_OFFSET;
			dark_b_s1     <= int'(pos_q) < STREAK_B_OFFSET;
			first_s1      <= first_q;
			mod7_s1       <= mod7_q;
			fwd_a_s1      <= valid_s1 && (slot_a_s1 == slot_a_q);
			fwd_b_s1      <= valid_s1 && (slot_b_s1 == slot_b_q);
			fwd_a_data_s1 <= old_a;
			fwd_b_data_s1 <= old_b;
		end
	end

	lts_ram #(.WIDTH($bits(led_entry_t)), .DEPTH(LED_COUNT)) u_led_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (idx_s1),
		.wdata (main_wr),
		.re    (accept),
		.raddr (pos_q),
		.rdata (main_rd)
	);

	lts_ram #(.WIDTH($bits(color_t)), .DEPTH(STREAK_A_OFFSET)) u_hist_a_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (slot_a_s1),
		.wdata (old_a),
		.re    (accept),
		.raddr (slot_a_q),
		.rdata (hist_a_rd)
	);

	lts_ram #(.WIDTH($bits(color_t)), .DEPTH(STREAK_B_OFFSET)) u_hist_b_ram (
		.clk   (clk),
		.we    (valid_s1),
		.waddr (slot_b_s1),
		.wdata (old_b),
		.re    (accept),
		.raddr (slot_b_q),
		.rdata (hist_b_rd)
	);

	always_comb begin
		rst_code   = mod7_s1 + 3'd1;
		rst_base.g = rst_code[2] ? RST_BASE_LEVEL : 8'd0;
		rst_base.r = rst_code[1] ? RST_BASE_LEVEL : 8'd0;
		rst_base.b = rst_code[0] ? RST_BASE_LEVEL : 8'd0;

		base_cur = first_s1 ? rst_base : main_rd.base;
		old_a    = first_s1 ? '0 : main_rd.sa;
		old_b    = first_s1 ? '0 : main_rd.sb;
		prev_a   = fwd_a_s1 ? fwd_a_data_s1 : hist_a_rd;
		prev_b   = fwd_b_s1 ? fwd_b_data_s1 : hist_b_rd;

		base_new.g = walk_ch(base_cur.g, step_g_s1, base_min_q, base_max_q);
		base_new.r = walk_ch(base_cur.r, step_r_s1, base_min_q, base_max_q);
		base_new.b = walk_ch(base_cur.b, step_b_s1, base_min_q, base_max_q);

		if (fire_a_s1) begin
			new_a = '{g: flash_peak_q, r: flash_peak_q, b: flash_peak_q};
		end else if (dark_a_s1) begin
			new_a = '0;
		end else begin
			new_a.g = decay_ch(prev_a.g, decay_step_q);
			new_a.r = decay_ch(prev_a.r, decay_step_q);
			new_a.b = decay_ch(prev_a.b, decay_step_q);
		end

		if (fire_b_s1) begin
			new_b = '{g: flash_peak_q, r: flash_peak_q, b: flash_peak_q};
		end else if (dark_b_s1) begin
			new_b = '0;
		end else begin
			new_b.g = decay_ch(prev_b.g, decay_step_q);
			new_b.r = decay_ch(prev_b.r, decay_step_q);
			new_b.b = decay_ch(prev_b.b, decay_step_q);
		end

		main_wr.base = base_new;
		main_wr.sa   = new_a;
		main_wr.sb   = new_b;

		idx_ext           = {8'd0, idx_s1};
		push_item.index   = idx_ext[7:0];
		push_item.color.g = merge_ch(base_new.g, new_a.g, new_b.g, out_min_q, out_max_q);
		push_item.color.r = merge_ch(base_new.r, new_a.r, new_b.r, out_min_q, out_max_q);
		push_item.color.b = merge_ch(base_new.b, new_a.b, new_b.b, out_min_q, out_max_q);
		push_item.last    = idx_s1 == LAST_IDX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (valid_s1) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(valid_s1) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
	end

	assign out_valid   = cnt_q != 2'd0;
	assign pixel_index = fifo_q[rd_ptr_q].index;
	assign out_green   = fifo_q[rd_ptr_q].color.g;
	assign out_red     = fifo_q[rd_ptr_q].color.r;
	assign out_blue    = fifo_q[rd_ptr_q].color.b;
	assign frame_last  = fifo_q[rd_ptr_q].last;

endmodule
